FILE: rtl/core/ptrl_pkg.sv
// Shared constants, types and helpers for the ramp-limited Tustin PID controller.
package ptrl_pkg;

  localparam int DATA_W    = 32;
  localparam int TIME_W    = 32;
  localparam int LIM_W     = 31;
  localparam int DT_W      = 19;
  localparam int CFG_IDX_W = 3;
  localparam int Q_FRAC    = 16;
  localparam int SUM_W     = DATA_W + 2;

  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DVD_W     = 51;
  localparam int DVS_W     = 20;
  localparam int QUO_W     = 32;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int DT_MAX_US     = 500000;
  localparam int DT_DEFAULT_US = 1000;
  localparam int US_PER_S      = 1000000;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_RATE = 3'd4;

  localparam logic signed [PROD_W-1:0] S32_MAX = {{(PROD_W-DATA_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [PROD_W-1:0] S32_MIN = {{(PROD_W-DATA_W){1'b1}}, 32'h8000_0000};

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // floor(p / 2^16), saturated to signed 32 bit
  function automatic logic signed [DATA_W-1:0] sat_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> Q_FRAC;
    if (s > S32_MAX) begin
      sat_q16 = S32_MAX[DATA_W-1:0];
    end else if (s < S32_MIN) begin
      sat_q16 = S32_MIN[DATA_W-1:0];
    end else begin
      sat_q16 = s[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/ptrl_ifs.sv
// Valid/ready channel interfaces for controller requests and results.
interface ptrl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ptrl_pkg::DATA_W-1:0]    err_sample;
  logic        [ptrl_pkg::TIME_W-1:0]    time_us;

  modport source (output valid, output err_sample, output time_us, input ready);
  modport sink   (input valid, input err_sample, input time_us, output ready);
endinterface

interface ptrl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ptrl_pkg::DATA_W-1:0]    drive_out;

  modport source (output valid, output drive_out, input ready);
  modport sink   (input valid, input drive_out, output ready);
endinterface

FILE: rtl/core/ptrl_div.sv
// Unsigned radix-4 restoring divider: 51-bit dividend, 20-bit divisor, 32-bit quotient.
module ptrl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ptrl_pkg::DVD_W-1:0]    dividend,
  input  logic [ptrl_pkg::DVS_W-1:0]    divisor,
  output logic [ptrl_pkg::QUO_W-1:0]    quot,
  output ptrl_pkg::div_stat_t           stat
);
  import ptrl_pkg::*;

  localparam int HI_W = DVD_W - QUO_W;

  logic             busy_r, done_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [QUO_W-1:0] quo_r;

  logic [DVS_W:0]   r1, r2, r1s, r2s;
  logic             b1, b2;
  logic [DVS_W-1:0] hi_part;

  assign hi_part = {{(DVS_W-HI_W){1'b0}}, dividend[DVD_W-1:QUO_W]};

  always_comb begin
    r1  = {rem_r, quo_r[QUO_W-1]};
    b1  = (r1 >= {1'b0, dvs_r});
    r1s = b1 ? (r1 - {1'b0, dvs_r}) : r1;
    r2  = {r1s[DVS_W-1:0], quo_r[QUO_W-2]};
    b2  = (r2 >= {1'b0, dvs_r});
    r2s = b2 ? (r2 - {1'b0, dvs_r}) : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient would not fit in 32 bits
      ovf_r <= (hi_part >= divisor);
      rem_r <= hi_part;
      quo_r <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= r2s[DVS_W-1:0];
      quo_r <= {quo_r[QUO_W-3:0], b1, b2};
    end
  end

  assign quot      = quo_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

FILE: rtl/core/pid_tustin_ramp_limited.sv
// PID controller, Tustin integral, output clamp and ramp limit (top level).
// Each request takes two passes of the shared radix-4 divider (three when ramp_rate is
//   nonzero) and six uses of one 33x33 multiplier; a new request is accepted only after
//   the previous result has been loaded into the output register.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, rst_n low) clears history, gains and ramp; out_limit to max.
module pid_tustin_ramp_limited (
  input  logic                              clk,
  input  logic                              rst_n,
  ptrl_in_if.sink                           in_ch,
  ptrl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ptrl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ptrl_pkg::DATA_W-1:0]       cfg_wdata
);
  import ptrl_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_MP        = 4'd1;
  localparam logic [3:0] ST_MI        = 4'd2;
  localparam logic [3:0] ST_MD        = 4'd3;
  localparam logic [3:0] ST_MIDT      = 4'd4;
  localparam logic [3:0] ST_DIVI_GO   = 4'd5;
  localparam logic [3:0] ST_DIVI_WAIT = 4'd6;
  localparam logic [3:0] ST_DIVD_GO   = 4'd7;
  localparam logic [3:0] ST_DIVD_WAIT = 4'd8;
  localparam logic [3:0] ST_SUM       = 4'd9;
  localparam logic [3:0] ST_DIVR_GO   = 4'd10;
  localparam logic [3:0] ST_DIVR_WAIT = 4'd11;
  localparam logic [3:0] ST_OUT       = 4'd12;

  // configuration
  logic signed [DATA_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic        [LIM_W-1:0]  lim_r, ramp_r;

  // history
  logic signed [DATA_W-1:0] integ_acc_r, last_out_r, last_err_r;
  logic        [TIME_W-1:0] last_time_r;

  // sequencer and work registers
  logic [3:0]               state_r, state_nxt;
  logic signed [DATA_W-1:0] err_r, avg_r, prop_r, irate_r, integ_r, deriv_r, total_r;
  logic        [TIME_W-1:0] now_r;
  logic        [DT_W-1:0]   dt_r;
  logic signed [DATA_W:0]   diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic        [DATA_W-1:0] qmag_r;
  logic                     q_neg_r, q_ovf_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;

  logic                     in_acc, out_load;
  logic        [TIME_W-1:0] dt_raw;
  logic        [DT_W-1:0]   dt_nxt;
  logic signed [DATA_W:0]   err_sum, diff_nxt;
  logic signed [DATA_W-1:0] avg_nxt;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  logic signed [PROD_W-1:0] q_sh, q_negv;
  logic                     q_ovf_nxt, q_neg_nxt;
  logic        [DATA_W-1:0] qmag_nxt, irate_mag, irate_neg_v;

  logic                     div_start;
  logic        [DVS_W-1:0]  div_dvs;
  logic        [QUO_W-1:0]  quot;
  div_stat_t                stat;

  logic signed [SUM_W-1:0]  lim_pos, lim_neg, quot_s, inc_s, integ_sum, integ_nxt;
  logic signed [SUM_W-1:0]  tot_sum, tot_nxt, lo_s, tot_s, delta, ramp_nxt;
  logic signed [DATA_W-1:0] deriv_nxt;
  logic        [DATA_W-1:0] quot_neg;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_out = out_data_r;

  // elapsed time and error combinations at accept
  always_comb begin
    dt_raw   = in_ch.time_us - last_time_r;
    dt_nxt   = ((dt_raw == '0) || (dt_raw > TIME_W'(DT_MAX_US)))
               ? DT_W'(DT_DEFAULT_US) : dt_raw[DT_W-1:0];
    err_sum  = {in_ch.err_sample[DATA_W-1], in_ch.err_sample}
             + {last_err_r[DATA_W-1], last_err_r};
    avg_nxt  = err_sum[DATA_W:1];
    diff_nxt = {in_ch.err_sample[DATA_W-1], in_ch.err_sample}
             - {last_err_r[DATA_W-1], last_err_r};
  end

  // magnitude helpers
  always_comb begin
    irate_neg_v = -irate_r;
    irate_mag   = irate_r[DATA_W-1] ? irate_neg_v : irate_r;
    q_sh        = prod_r >>> Q_FRAC;
    q_negv      = -q_sh;
    q_ovf_nxt   = (q_sh > S32_MAX) || (q_sh < S32_MIN);
    q_neg_nxt   = q_sh[PROD_W-1];
    qmag_nxt    = q_neg_nxt ? q_negv[DATA_W-1:0] : q_sh[DATA_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_MP: begin
        mul_a = {gain_p_r[DATA_W-1], gain_p_r};
        mul_b = {err_r[DATA_W-1], err_r};
      end
      ST_MI: begin
        mul_a = {gain_i_r[DATA_W-1], gain_i_r};
        mul_b = {avg_r[DATA_W-1], avg_r};
      end
      ST_MD: begin
        mul_a = {gain_d_r[DATA_W-1], gain_d_r};
        mul_b = diff_r;
      end
      ST_MIDT: begin
        mul_a = {1'b0, irate_mag};
        mul_b = {{(MUL_W-DT_W){1'b0}}, dt_r};
      end
      ST_DIVI_GO: begin
        mul_a = {1'b0, qmag_r};
        mul_b = MUL_W'(US_PER_S);
      end
      ST_DIVD_GO: begin
        mul_a = {{(MUL_W-LIM_W){1'b0}}, ramp_r};
        mul_b = {{(MUL_W-DT_W){1'b0}}, dt_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // shared divider
  always_comb begin
    div_start = 1'b0;
    div_dvs   = DVS_W'(US_PER_S);
    case (state_r)
      ST_DIVI_GO: div_start = 1'b1;
      ST_DIVD_GO: begin
        div_start = 1'b1;
        div_dvs   = {{(DVS_W-DT_W){1'b0}}, dt_r};
      end
      ST_DIVR_GO: div_start = 1'b1;
      default: div_start = 1'b0;
    endcase
  end

  ptrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[DVD_W-1:0]),
    .divisor  (div_dvs),
    .quot     (quot),
    .stat     (stat)
  );

  // post-divide arithmetic: integral, derivative, sum, ramp
  always_comb begin
    lim_pos  = $signed({{(SUM_W-LIM_W){1'b0}}, lim_r});
    lim_neg  = -lim_pos;
    quot_s   = $signed({{(SUM_W-QUO_W){1'b0}}, quot});
    quot_neg = -quot;

    inc_s     = irate_r[DATA_W-1] ? -quot_s : quot_s;
    integ_sum = {{(SUM_W-DATA_W){integ_acc_r[DATA_W-1]}}, integ_acc_r} + inc_s;
    if (integ_sum > lim_pos) begin
      integ_nxt = lim_pos;
    end else if (integ_sum < lim_neg) begin
      integ_nxt = lim_neg;
    end else begin
      integ_nxt = integ_sum;
    end

    if (q_ovf_r || stat.ovf) begin
      deriv_nxt = q_neg_r ? S32_MIN[DATA_W-1:0] : S32_MAX[DATA_W-1:0];
    end else if (!q_neg_r) begin
      deriv_nxt = quot[QUO_W-1] ? S32_MAX[DATA_W-1:0] : $signed(quot);
    end else if (quot > {1'b1, {(QUO_W-1){1'b0}}}) begin
      deriv_nxt = S32_MIN[DATA_W-1:0];
    end else begin
      deriv_nxt = $signed(quot_neg);
    end

    tot_sum = {{(SUM_W-DATA_W){prop_r[DATA_W-1]}}, prop_r}
            + {{(SUM_W-DATA_W){integ_r[DATA_W-1]}}, integ_r}
            + {{(SUM_W-DATA_W){deriv_r[DATA_W-1]}}, deriv_r};
    if (tot_sum > lim_pos) begin
      tot_nxt = lim_pos;
    end else if (tot_sum < lim_neg) begin
      tot_nxt = lim_neg;
    end else begin
      tot_nxt = tot_sum;
    end

    lo_s  = {{(SUM_W-DATA_W){last_out_r[DATA_W-1]}}, last_out_r};
    tot_s = {{(SUM_W-DATA_W){total_r[DATA_W-1]}}, total_r};
    delta = tot_s - lo_s;
    if (delta > quot_s) begin
      ramp_nxt = lo_s + quot_s;
    end else if (delta < -quot_s) begin
      ramp_nxt = lo_s - quot_s;
    end else begin
      ramp_nxt = tot_s;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_acc) state_nxt = ST_MP;
      ST_MP:        state_nxt = ST_MI;
      ST_MI:        state_nxt = ST_MD;
      ST_MD:        state_nxt = ST_MIDT;
      ST_MIDT:      state_nxt = ST_DIVI_GO;
      ST_DIVI_GO:   state_nxt = ST_DIVI_WAIT;
      ST_DIVI_WAIT: if (stat.done) state_nxt = ST_DIVD_GO;
      ST_DIVD_GO:   state_nxt = ST_DIVD_WAIT;
      ST_DIVD_WAIT: if (stat.done) state_nxt = ST_SUM;
      ST_SUM:       state_nxt = (ramp_r != '0) ? ST_DIVR_GO : ST_OUT;
      ST_DIVR_GO:   state_nxt = ST_DIVR_WAIT;
      ST_DIVR_WAIT: if (stat.done) state_nxt = ST_OUT;
      ST_OUT:       if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      lim_r       <= '1;
      ramp_r      <= '0;
      integ_acc_r <= '0;
      last_out_r  <= '0;
      last_err_r  <= '0;
      last_time_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        integ_acc_r <= integ_r;
        last_out_r  <= total_r;
        last_err_r  <= err_r;
        last_time_r <= now_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_GAIN_P:    gain_p_r <= cfg_wdata;
          REG_GAIN_I:    gain_i_r <= cfg_wdata;
          REG_GAIN_D:    gain_d_r <= cfg_wdata;
          REG_OUT_LIMIT: lim_r    <= cfg_wdata[LIM_W-1:0];
          REG_RAMP_RATE: ramp_r   <= cfg_wdata[LIM_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r  <= in_ch.err_sample;
      now_r  <= in_ch.time_us;
      dt_r   <= dt_nxt;
      avg_r  <= avg_nxt;
      diff_r <= diff_nxt;
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ST_MI) begin
      prop_r <= sat_q16(prod_r);
    end
    if (state_r == ST_MD) begin
      irate_r <= sat_q16(prod_r);
    end
    if (state_r == ST_MIDT) begin
      qmag_r  <= qmag_nxt;
      q_neg_r <= q_neg_nxt;
      q_ovf_r <= q_ovf_nxt;
    end
    if ((state_r == ST_DIVI_WAIT) && stat.done) begin
      integ_r <= integ_nxt[DATA_W-1:0];
    end
    if ((state_r == ST_DIVD_WAIT) && stat.done) begin
      deriv_r <= deriv_nxt;
    end
    if (state_r == ST_SUM) begin
      total_r <= tot_nxt[DATA_W-1:0];
    end
    if ((state_r == ST_DIVR_WAIT) && stat.done) begin
      total_r <= ramp_nxt[DATA_W-1:0];
    end
    if (out_load) begin
      out_data_r <= total_r;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MP))
    else $error("request accept did not start the sequence");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> ((state_r == ST_DIVI_WAIT) || (state_r == ST_DIVD_WAIT) ||
                   (state_r == ST_DIVR_WAIT)))
    else $error("divider finished outside a wait state");

  a_integ_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.done && (state_r == ST_DIVI_WAIT)) |-> !stat.ovf)
    else $error("integral increment quotient overflowed");

  a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (($signed(integ_acc_r) <= $signed({1'b0, $past(lim_r)})) &&
                  ($signed(integ_acc_r) >= -$signed({1'b0, $past(lim_r)}))))
    else $error("stored integral outside limit");

endmodule
